### rtl/cgd_pkg.sv
// Shared constants, types and state codes of the chain switch gesture decoder.
package cgd_pkg;

	localparam int CHANNELS_PER_MODULE = 6;
	localparam int MAX_MODULES         = 6;
	localparam int TOTAL_CHANNELS      = MAX_MODULES * CHANNELS_PER_MODULE;
	localparam int CH_W                = $clog2(TOTAL_CHANNELS + 1);
	localparam int MOD_W               = $clog2(MAX_MODULES);
	localparam int CHJ_W               = $clog2(CHANNELS_PER_MODULE);
	localparam int SW_W                = 8 * MAX_MODULES;
	localparam int PATCH_W             = TOTAL_CHANNELS;
	localparam int TICK_W              = 16;
	localparam int CFG_IDX_W           = 2;
	localparam int CFG_DATA_W          = 15;
	localparam int KIND_W              = 2;

	localparam logic [7:0]               SUSPEND_MASK      = 8'hff;
	localparam logic signed [TICK_W-1:0] LONG_PRESS_TICKS  = 16'sd500;
	localparam logic signed [TICK_W-1:0] TAP_TICKS         = 16'sd5;
	localparam logic signed [TICK_W-1:0] BLOCKED           = -16'sd1;
	localparam logic signed [TICK_W-1:0] COUNT_MAX         = 16'sd32767;

	localparam logic [2:0]            CHAIN_SIZE_RST      = 3'd1;
	localparam logic [2:0]            MODULE_POSITION_RST = 3'd0;
	localparam logic [CFG_DATA_W-1:0] MODE_TOGGLE_RST     = 15'd5000;

	typedef enum logic [KIND_W-1:0] {
		REQ_NONE    = 2'd0,
		REQ_LOOP    = 2'd1,
		REQ_SEGMENT = 2'd2
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHAIN_SIZE      = 2'd0,
		CFG_MODULE_POSITION = 2'd1,
		CFG_MODE_TOGGLE     = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAN,
		ST_EVAL,
		ST_BLOCK_FIRST,
		ST_LOOP_WAIT,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		LW_IDLE,
		LW_WALK,
		LW_FIN
	} lw_state_t;

	typedef struct packed {
		logic            start;
		logic [CH_W-1:0] ls;
		logic [CH_W-1:0] le;
	} loop_cmd_t;

	typedef struct packed {
		logic            done;
		logic            ok;
		logic [CH_W-1:0] gs;
		logic [CH_W-1:0] ls;
		logic [CH_W-1:0] le;
		logic [CH_W-1:0] ge;
	} loop_res_t;

endpackage

### rtl/cgd_if.sv
// Handshake channel interfaces: tick input, request output and configuration write.
interface cgd_in_if;
	logic                        valid;
	logic                        ready;
	logic [cgd_pkg::SW_W-1:0]    switch_bits;
	logic [cgd_pkg::PATCH_W-1:0] patched_bits;

	modport source (output valid, output switch_bits, output patched_bits, input ready);
	modport sink   (input valid, input switch_bits, input patched_bits, output ready);
endinterface

interface cgd_out_if;
	logic                       valid;
	logic                       ready;
	logic [cgd_pkg::KIND_W-1:0] request_kind;
	logic [cgd_pkg::CH_W-1:0]   group_first;
	logic [cgd_pkg::CH_W-1:0]   loop_first;
	logic [cgd_pkg::CH_W-1:0]   loop_last;
	logic [cgd_pkg::CH_W-1:0]   group_limit;

	modport source (output valid, output request_kind, output group_first, output loop_first,
		output loop_last, output group_limit, input ready);
	modport sink   (input valid, input request_kind, input group_first, input loop_first,
		input loop_last, input group_limit, output ready);
endinterface

interface cgd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cgd_pkg::CFG_IDX_W-1:0]  index;
	logic [cgd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cgd_loop_unit.sv
// Loop span checker: walks the patched channels one per cycle and builds a set-loop request.
module cgd_loop_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cgd_pkg::loop_cmd_t          cmd,
	input  logic [cgd_pkg::PATCH_W-1:0] patched,
	input  logic [cgd_pkg::CH_W-1:0]    walk_n,
	output cgd_pkg::loop_res_t          res
);

	cgd_pkg::lw_state_t state_q, state_d;

	logic [cgd_pkg::CH_W-1:0] ch_q;
	logic [cgd_pkg::CH_W-1:0] ls_q;
	logic [cgd_pkg::CH_W-1:0] le_q;
	logic [cgd_pkg::CH_W-1:0] gs_q;
	logic [cgd_pkg::CH_W-1:0] ge_q;
	logic                     bad_q;

	logic                     ch_patched;
	logic                     last_ch;
	logic [cgd_pkg::CH_W-1:0] gs_f;
	logic [cgd_pkg::CH_W-1:0] ge_f;
	logic [cgd_pkg::CH_W-1:0] ls_f;
	logic                     bad_f;

	assign ch_patched = patched[ch_q];
	assign last_ch    = (ch_q == cgd_pkg::CH_W'(walk_n - 1'b1));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgd_pkg::LW_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through start, walk and finish
	always_comb begin
		state_d = state_q;
		case (state_q)
			cgd_pkg::LW_IDLE: begin
				if (cmd.start) state_d = cgd_pkg::LW_WALK;
			end
			cgd_pkg::LW_WALK: begin
				if (last_ch) state_d = cgd_pkg::LW_FIN;
			end
			cgd_pkg::LW_FIN: begin
				state_d = cgd_pkg::LW_IDLE;
			end
			default: begin
				state_d = cgd_pkg::LW_IDLE;
			end
		endcase
	end

	// Track group bounds and span consistency, one channel per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ls_q  <= cmd.ls;
			le_q  <= cmd.le;
			gs_q  <= '0;
			ge_q  <= walk_n;
			bad_q <= 1'b0;
			ch_q  <= '0;
		end else if (state_q == cgd_pkg::LW_WALK) begin
			if (ch_patched) begin
				if (ch_q <= ls_q) begin
					gs_q <= ch_q;
				end else if (ch_q >= le_q && ch_q < ge_q) begin
					ge_q <= ch_q;
				end
				if (ch_q > ls_q && ch_q < le_q) bad_q <= 1'b1;
			end
			ch_q <= ch_q + 1'b1;
		end
	end

	// Resolve the unpatched first group and the degenerate end bound
	always_comb begin
		gs_f  = gs_q;
		ge_f  = ge_q;
		ls_f  = ls_q;
		bad_f = bad_q;
		if (gs_q == '0 && !patched[0]) begin
			if (ls_q != le_q) begin
				bad_f = 1'b1;
			end else begin
				gs_f = le_q;
				ge_f = le_q;
				ls_f = le_q;
			end
		end
		if (ge_f == le_q && gs_f != ge_f) bad_f = 1'b1;
	end

	assign res.done = (state_q == cgd_pkg::LW_FIN);
	assign res.ok   = !bad_f;
	assign res.gs   = gs_f;
	assign res.ls   = ls_f;
	assign res.le   = le_q;
	assign res.ge   = ge_f;

endmodule

### rtl/chain_switch_gesture_decoder_unit.sv
// Top level of the chain switch gesture decoder: press counters, channel sequencer, output.
//
//  channel   role     moves per transaction
//  tick_in   sink     switch_bits, patched_bits of every module for one tick
//  req_out   source   request_kind, group_first, loop_first, loop_last, group_limit
//  cfg       sink     index, data: one register write
//
// Sequence: the tick is taken, then its result is handed to the output register. A module that is
// last in the chain first walks min(chain_size, 6) * 6 channels: a channel of a suspended
// module is marked blocked directly, any other channel has a counter read, then an update, and
// each loop request adds a walk over the channels in the chain, after ST_BLOCK_FIRST for a pair.
// Reset: press counters read as zero through per-entry valid bits; no clearing pass.
// Stalls: the next tick is taken while a result waits; its own result waits for the register.
module chain_switch_gesture_decoder_unit (
	input logic        clk,
	input logic        arst_n,
	cgd_in_if.sink     tick_in,
	cgd_out_if.source  req_out,
	cgd_cfg_if.sink    cfg
);

	cgd_pkg::ctl_state_t state_q, state_d;

	// Configuration
	logic [2:0]                     chain_size_q;
	logic [2:0]                     module_position_q;
	logic [cgd_pkg::CFG_DATA_W-1:0] mode_toggle_q;

	// Tick payload and walk position
	logic [cgd_pkg::SW_W-1:0]    sw_q;
	logic [cgd_pkg::PATCH_W-1:0] patched_q;
	logic [cgd_pkg::CH_W-1:0]    walk_n_q;
	logic [cgd_pkg::CH_W-1:0]    idx_q;
	logic [cgd_pkg::MOD_W-1:0]   mod_q;
	logic [cgd_pkg::CHJ_W-1:0]   j_q;
	logic [cgd_pkg::CH_W-1:0]    first_q;
	logic                        have_first_q;

	// Request found so far in this tick
	cgd_pkg::req_kind_t       req_kind_q;
	logic [cgd_pkg::CH_W-1:0] req_a0_q;
	logic [cgd_pkg::CH_W-1:0] req_a1_q;
	logic [cgd_pkg::CH_W-1:0] req_a2_q;
	logic [cgd_pkg::CH_W-1:0] req_a3_q;

	// Output register
	logic                     out_valid_q;
	cgd_pkg::req_kind_t       out_kind_q;
	logic [cgd_pkg::CH_W-1:0] out_a0_q;
	logic [cgd_pkg::CH_W-1:0] out_a1_q;
	logic [cgd_pkg::CH_W-1:0] out_a2_q;
	logic [cgd_pkg::CH_W-1:0] out_a3_q;

	// Press counter memory
	logic [cgd_pkg::TICK_W-1:0]         mem [cgd_pkg::TOTAL_CHANNELS];
	logic [cgd_pkg::TOTAL_CHANNELS-1:0] vld_q;
	logic [cgd_pkg::TICK_W-1:0]         rd_data_q;
	logic                               rd_vld_q;

	// Sequencer strobes
	logic                       accept;
	logic                       active;
	logic                       mem_we;
	logic [cgd_pkg::CH_W-1:0]   mem_wa;
	logic [cgd_pkg::TICK_W-1:0] mem_wd;
	logic                       rd_en;
	logic                       advance;
	logic                       set_first;
	logic                       req_seg;
	logic                       req_loop_load;
	logic                       out_load;
	cgd_pkg::loop_cmd_t         loop_cmd;
	cgd_pkg::loop_res_t         loop_res;

	logic [7:0]                        sw_byte;
	logic                              suspended;
	logic                              pressed;
	logic                              last_ch;
	logic signed [cgd_pkg::TICK_W-1:0] t;
	logic signed [cgd_pkg::TICK_W-1:0] mode_toggle_s;
	logic [2:0]                        walk_modules;
	cgd_pkg::ctl_state_t               adv_state;

	assign accept        = tick_in.valid && tick_in.ready;
	assign active        = (chain_size_q != 3'd0) && (module_position_q == 3'(chain_size_q - 1'b1));
	assign walk_modules  = (chain_size_q > 3'(cgd_pkg::MAX_MODULES)) ?
		3'(cgd_pkg::MAX_MODULES) : chain_size_q;
	assign sw_byte       = sw_q[8*mod_q +: 8];
	assign suspended     = (sw_byte == cgd_pkg::SUSPEND_MASK);
	assign pressed       = sw_byte[j_q];
	assign last_ch       = (idx_q == cgd_pkg::CH_W'(walk_n_q - 1'b1));
	assign adv_state     = last_ch ? cgd_pkg::ST_DONE : cgd_pkg::ST_CHAN;
	assign t             = rd_vld_q ? signed'(rd_data_q) : '0;
	assign mode_toggle_s = signed'({1'b0, mode_toggle_q});

	assign tick_in.ready = (state_q == cgd_pkg::ST_IDLE);
	assign cfg.ready     = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_size_q      <= cgd_pkg::CHAIN_SIZE_RST;
			module_position_q <= cgd_pkg::MODULE_POSITION_RST;
			mode_toggle_q     <= cgd_pkg::MODE_TOGGLE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cgd_pkg::cfg_index_t'(cfg.index))
				cgd_pkg::CFG_CHAIN_SIZE:      chain_size_q      <= cfg.data[2:0];
				cgd_pkg::CFG_MODULE_POSITION: module_position_q <= cfg.data[2:0];
				cgd_pkg::CFG_MODE_TOGGLE:     mode_toggle_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes of the channel sequencer
	always_comb begin
		state_d       = state_q;
		mem_we        = 1'b0;
		mem_wa        = idx_q;
		mem_wd        = '0;
		rd_en         = 1'b0;
		advance       = 1'b0;
		set_first     = 1'b0;
		req_seg       = 1'b0;
		req_loop_load = 1'b0;
		out_load      = 1'b0;
		loop_cmd      = '{start: 1'b0, ls: idx_q, le: idx_q};
		case (state_q)
			cgd_pkg::ST_IDLE: begin
				if (accept) state_d = active ? cgd_pkg::ST_CHAN : cgd_pkg::ST_DONE;
			end
			cgd_pkg::ST_CHAN: begin
				if (suspended) begin
					mem_we  = 1'b1;
					mem_wd  = cgd_pkg::BLOCKED;
					advance = 1'b1;
					state_d = adv_state;
				end else begin
					rd_en   = 1'b1;
					state_d = cgd_pkg::ST_EVAL;
				end
			end
			cgd_pkg::ST_EVAL: begin
				if (pressed) begin
					if (t == cgd_pkg::BLOCKED) begin
						advance = 1'b1;
						state_d = adv_state;
					end else if (have_first_q) begin
						mem_we  = 1'b1;
						mem_wd  = cgd_pkg::BLOCKED;
						state_d = cgd_pkg::ST_BLOCK_FIRST;
					end else begin
						mem_we    = 1'b1;
						mem_wd    = (t < cgd_pkg::COUNT_MAX) ? t + 16'sd1 : t;
						set_first = 1'b1;
						advance   = 1'b1;
						state_d   = adv_state;
					end
				end else begin
					mem_we = 1'b1;
					mem_wd = '0;
					if (t > cgd_pkg::LONG_PRESS_TICKS && t < mode_toggle_s) begin
						loop_cmd.start = 1'b1;
						state_d        = cgd_pkg::ST_LOOP_WAIT;
					end else begin
						req_seg = (t <= cgd_pkg::LONG_PRESS_TICKS) && (t > cgd_pkg::TAP_TICKS);
						advance = 1'b1;
						state_d = adv_state;
					end
				end
			end
			cgd_pkg::ST_BLOCK_FIRST: begin
				mem_we         = 1'b1;
				mem_wa         = first_q;
				mem_wd         = cgd_pkg::BLOCKED;
				loop_cmd.start = 1'b1;
				loop_cmd.ls    = first_q;
				state_d        = cgd_pkg::ST_LOOP_WAIT;
			end
			cgd_pkg::ST_LOOP_WAIT: begin
				if (loop_res.done) begin
					req_loop_load = 1'b1;
					advance       = 1'b1;
					state_d       = adv_state;
				end
			end
			cgd_pkg::ST_DONE: begin
				if (!out_valid_q || req_out.ready) begin
					out_load = 1'b1;
					state_d  = cgd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cgd_pkg::ST_IDLE;
			end
		endcase
	end

	// Latch the tick and step through the channels
	always_ff @(posedge clk) begin
		if (accept) begin
			sw_q      <= tick_in.switch_bits;
			patched_q <= tick_in.patched_bits;
			walk_n_q  <= cgd_pkg::CH_W'(walk_modules * cgd_pkg::CHANNELS_PER_MODULE);
			idx_q     <= '0;
			mod_q     <= '0;
			j_q       <= '0;
		end else if (advance) begin
			idx_q <= idx_q + 1'b1;
			if (j_q == cgd_pkg::CHJ_W'(cgd_pkg::CHANNELS_PER_MODULE - 1)) begin
				j_q   <= '0;
				mod_q <= mod_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
		if (set_first) first_q <= idx_q;
	end

	// Track the first held channel of the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
		end else if (accept) begin
			have_first_q <= 1'b0;
		end else if (set_first) begin
			have_first_q <= 1'b1;
		end
	end

	// Keep the last request found in the tick
	always_ff @(posedge clk) begin
		if (accept) begin
			req_kind_q <= cgd_pkg::REQ_NONE;
			req_a0_q   <= '0;
			req_a1_q   <= '0;
			req_a2_q   <= '0;
			req_a3_q   <= '0;
		end else if (req_seg) begin
			req_kind_q <= cgd_pkg::REQ_SEGMENT;
			req_a0_q   <= idx_q;
			req_a1_q   <= '0;
			req_a2_q   <= '0;
			req_a3_q   <= '0;
		end else if (req_loop_load) begin
			if (loop_res.ok) begin
				req_kind_q <= cgd_pkg::REQ_LOOP;
				req_a0_q   <= loop_res.gs;
				req_a1_q   <= loop_res.ls;
				req_a2_q   <= loop_res.le;
				req_a3_q   <= loop_res.ge;
			end else begin
				req_kind_q <= cgd_pkg::REQ_NONE;
				req_a0_q   <= '0;
				req_a1_q   <= '0;
				req_a2_q   <= '0;
				req_a3_q   <= '0;
			end
		end
	end

	// Counter memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_q <= mem[idx_q];
	end

	// Valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) vld_q[mem_wa] <= 1'b1;
			if (rd_en) rd_vld_q <= vld_q[idx_q];
		end
	end

	// Output transaction valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (req_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= req_kind_q;
			out_a0_q   <= req_a0_q;
			out_a1_q   <= req_a1_q;
			out_a2_q   <= req_a2_q;
			out_a3_q   <= req_a3_q;
		end
	end

	assign req_out.valid        = out_valid_q;
	assign req_out.request_kind = out_kind_q;
	assign req_out.group_first  = out_a0_q;
	assign req_out.loop_first   = out_a1_q;
	assign req_out.loop_last    = out_a2_q;
	assign req_out.group_limit  = out_a3_q;

	cgd_loop_unit u_loop (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (loop_cmd),
		.patched (patched_q),
		.walk_n  (walk_n_q),
		.res     (loop_res)
	);

endmodule
